// ===== rtl/clipped_line_pixel_generator_macros.svh =====
// Assertion macros used by the top level of the line pixel generator.
`ifndef CLIPPED_LINE_PIXEL_GENERATOR_MACROS_SVH
`define CLIPPED_LINE_PIXEL_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLPG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/clpg_pkg.sv =====
// Shared types, constants and width helpers of the line pixel generator.
package clpg_pkg;

    localparam int FIELD_W    = 16;
    localparam int DIM_W      = 14;
    localparam int STRIDE_W   = 16;
    localparam int COLOR_W    = 32;
    localparam int INDEX_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Item kinds on the input side.
    typedef enum logic
    {
        KIND_START   = 1'b0,
        KIND_ADVANCE = 1'b1
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_ROW_STRIDE   = 2'd2
    } cfg_idx_t;

    // Frame geometry as seen by the pixel walker.
    typedef struct packed
    {
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
        logic [STRIDE_W-1:0] row_stride_words;
    } cfg_t;

    // One result beat.
    typedef struct packed
    {
        logic               valid_res;
        logic               on_screen;
        logic [INDEX_W-1:0] pixel_index;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } res_t;

    // Internal coordinate width: endpoints are sign-extended from at most 16 bits.
    function automatic int coord_bits(input int cb);
        coord_bits = (cb < FIELD_W) ? cb : FIELD_W;
    endfunction

    // Width of one command beat between front and back, see the command struct.
    function automatic int cmd_bits(input int cw);
        cmd_bits = 1 + 4 * cw + 2 * (cw + 1) + 4 + (cw + 3) + COLOR_W;
    endfunction

endpackage

// ===== rtl/clpg_fifo.sv =====
// Small first-in first-out queue with show-ahead read and a fill level.
module clpg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wdata,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rdata,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    // Status and handshake qualification.
    assign full    = (count_reg == LW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign level   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + LW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/clpg_front.sv =====
// Front end: accepts items and prepares line setup terms for start items.
module clpg_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  cmd_full,
    output logic                                  cmd_push,
    input  logic                                  kind,
    input  logic signed [clpg_pkg::FIELD_W-1:0]   start_x,
    input  logic signed [clpg_pkg::FIELD_W-1:0]   start_y,
    input  logic signed [clpg_pkg::FIELD_W-1:0]   end_x,
    input  logic signed [clpg_pkg::FIELD_W-1:0]   end_y,
    input  logic [clpg_pkg::COLOR_W-1:0]          color,
    output logic [clpg_pkg::cmd_bits(clpg_pkg::coord_bits(COORD_BITS))-1:0] cmd_data
);

    localparam int CW = clpg_pkg::coord_bits(COORD_BITS);
    localparam int DW = CW + 1;
    localparam int EW = CW + 3;

    typedef struct packed
    {
        clpg_pkg::kind_t               kind;
        logic signed [CW-1:0]          sx;
        logic signed [CW-1:0]          sy;
        logic signed [CW-1:0]          tx;
        logic signed [CW-1:0]          ty;
        logic [DW-1:0]                 dcol;
        logic [DW-1:0]                 drow;
        logic signed [1:0]             stc;
        logic signed [1:0]             str;
        logic signed [EW-1:0]          err;
        logic [clpg_pkg::COLOR_W-1:0]  color;
    } cmd_t;

    logic [CW-1:0] sx, sy, tx, ty;
    logic [DW-1:0] dx_fwd, dx_rev, dy_fwd, dy_rev;
    logic [DW-1:0] dcol, drow;
    cmd_t          cmd;

    // An item enters the command queue whenever it has room.
    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;

    // Endpoints keep only the coordinate width; the top bit is the sign.
    assign sx = start_x[CW-1:0];
    assign sy = start_y[CW-1:0];
    assign tx = end_x[CW-1:0];
    assign ty = end_y[CW-1:0];

    // Both differences are formed in parallel so the magnitude is a plain select.
    assign dx_fwd = {tx[CW-1], tx} - {sx[CW-1], sx};
    assign dx_rev = {sx[CW-1], sx} - {tx[CW-1], tx};
    assign dy_fwd = {ty[CW-1], ty} - {sy[CW-1], sy};
    assign dy_rev = {sy[CW-1], sy} - {ty[CW-1], ty};
    assign dcol   = dx_fwd[DW-1] ? dx_rev : dx_fwd;
    assign drow   = dy_fwd[DW-1] ? dy_rev : dy_fwd;

    // Pack the command beat with step directions and the initial error.
    always_comb
    begin
        cmd.kind  = clpg_pkg::kind_t'(kind);
        cmd.sx    = sx;
        cmd.sy    = sy;
        cmd.tx    = tx;
        cmd.ty    = ty;
        cmd.dcol  = dcol;
        cmd.drow  = drow;
        cmd.stc   = dx_fwd[DW-1] ? 2'sb11 : ((dx_fwd == '0) ? 2'sb00 : 2'sb01);
        cmd.str   = dy_fwd[DW-1] ? 2'sb11 : ((dy_fwd == '0) ? 2'sb00 : 2'sb01);
        cmd.err   = $signed({2'b00, dcol}) - $signed({2'b00, drow});
        cmd.color = color;
    end

    assign cmd_data = cmd;

endmodule

// ===== rtl/clpg_back.sv =====
// Back end: Bresenham stepper, clipping and framebuffer index computation.
module clpg_back #(
    parameter int COORD_BITS = 16,
    parameter int OUT_DEPTH  = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  clpg_pkg::cfg_t                        cfg,
    input  logic [clpg_pkg::cmd_bits(clpg_pkg::coord_bits(COORD_BITS))-1:0] cmd_data,
    input  logic                                  cmd_empty,
    output logic                                  cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]        out_level,
    output logic                                  out_push,
    output clpg_pkg::res_t                        out_data
);

    localparam int CW     = clpg_pkg::coord_bits(COORD_BITS);
    localparam int DW     = CW + 1;
    localparam int EW     = CW + 3;
    localparam int CMPW   = ((CW > clpg_pkg::DIM_W) ? CW : clpg_pkg::DIM_W) + 1;
    localparam int OUT_LW = $clog2(OUT_DEPTH + 1);
    localparam int PROD_W = clpg_pkg::DIM_W + clpg_pkg::STRIDE_W;

    typedef struct packed
    {
        clpg_pkg::kind_t               kind;
        logic signed [CW-1:0]          sx;
        logic signed [CW-1:0]          sy;
        logic signed [CW-1:0]          tx;
        logic signed [CW-1:0]          ty;
        logic [DW-1:0]                 dcol;
        logic [DW-1:0]                 drow;
        logic signed [1:0]             stc;
        logic signed [1:0]             str;
        logic signed [EW-1:0]          err;
        logic [clpg_pkg::COLOR_W-1:0]  color;
    } cmd_t;

    cmd_t cmd;

    // Line state.
    logic                          active_reg, active_next;
    logic [CW-1:0]                 cc_reg, cc_next;
    logic [CW-1:0]                 cr_reg, cr_next;
    logic [CW-1:0]                 tc_reg, tr_reg;
    logic [DW-1:0]                 dcol_reg, drow_reg;
    logic [1:0]                    stc_reg, str_reg;
    logic [EW-1:0]                 err_reg, err_next;
    logic [clpg_pkg::COLOR_W-1:0]  color_reg;

    // Pixel stage between the stepper and the index multiplier.
    logic                          p1_valid_reg;
    logic                          p1_res_reg;
    logic                          p1_on_reg;
    logic [clpg_pkg::DIM_W-1:0]    p1_col_reg;
    logic [clpg_pkg::DIM_W-1:0]    p1_row_reg;
    logic [clpg_pkg::COLOR_W-1:0]  p1_color_reg;
    logic                          p1_last_reg;

    logic                          is_start, act_sel, fire, on, fin;
    logic                          step_x, step_y;
    logic [CW-1:0]                 cc_sel, cr_sel, tc_sel, tr_sel;
    logic [DW-1:0]                 dcol_sel, drow_sel;
    logic [1:0]                    stc_sel, str_sel;
    logic [EW-1:0]                 err_sel;
    logic [clpg_pkg::COLOR_W-1:0]  color_sel;
    logic [EW:0]                   e2;
    logic [CMPW-1:0]               ccu, cru, wu, hu;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W:0]               sum;

    assign cmd = cmd_t'(cmd_data);

    // Take a command only when the result queue has room for it and the beat in flight.
    assign fire    = !cmd_empty &&
                     (({1'b0, out_level} + {{OUT_LW{1'b0}}, p1_valid_reg}) <
                      (OUT_LW + 1)'(OUT_DEPTH));
    assign cmd_pop = fire;

    // A start beat supplies fresh line state; an advance beat uses the stored state.
    assign is_start  = (cmd.kind == clpg_pkg::KIND_START);
    assign act_sel   = is_start || active_reg;
    assign cc_sel    = is_start ? cmd.sx    : cc_reg;
    assign cr_sel    = is_start ? cmd.sy    : cr_reg;
    assign tc_sel    = is_start ? cmd.tx    : tc_reg;
    assign tr_sel    = is_start ? cmd.ty    : tr_reg;
    assign dcol_sel  = is_start ? cmd.dcol  : dcol_reg;
    assign drow_sel  = is_start ? cmd.drow  : drow_reg;
    assign stc_sel   = is_start ? cmd.stc   : stc_reg;
    assign str_sel   = is_start ? cmd.str   : str_reg;
    assign err_sel   = is_start ? cmd.err   : err_reg;
    assign color_sel = is_start ? cmd.color : color_reg;

    // Clipping: negative coordinates are off screen, others compare unsigned.
    assign ccu = {{(CMPW-CW){1'b0}}, cc_sel};
    assign cru = {{(CMPW-CW){1'b0}}, cr_sel};
    assign wu  = {{(CMPW-clpg_pkg::DIM_W){1'b0}}, cfg.frame_width};
    assign hu  = {{(CMPW-clpg_pkg::DIM_W){1'b0}}, cfg.frame_height};
    assign on  = act_sel && !cc_sel[CW-1] && !cr_sel[CW-1] && (ccu < wu) && (cru < hu);
    assign fin = (cc_sel == tc_sel) && (cr_sel == tr_sel);

    // One Bresenham step from the selected state.
    assign e2     = {err_sel, 1'b0};
    assign step_x = $signed(e2) > -$signed({3'b000, drow_sel});
    assign step_y = $signed(e2) < $signed({3'b000, dcol_sel});

    always_comb
    begin
        cc_next     = cc_sel + (step_x ? {{(CW-2){stc_sel[1]}}, stc_sel} : CW'(0));
        cr_next     = cr_sel + (step_y ? {{(CW-2){str_sel[1]}}, str_sel} : CW'(0));
        err_next    = err_sel - (step_x ? {2'b00, drow_sel} : EW'(0))
                              + (step_y ? {2'b00, dcol_sel} : EW'(0));
        active_next = active_reg;
        if (fire)
        begin
            active_next = act_sel && !fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            p1_valid_reg <= fire;
        end
    end

    // Line state and pixel stage payload.
    always_ff @(posedge clk)
    begin
        if (fire && act_sel)
        begin
            cc_reg    <= cc_next;
            cr_reg    <= cr_next;
            err_reg   <= err_next;
            tc_reg    <= tc_sel;
            tr_reg    <= tr_sel;
            dcol_reg  <= dcol_sel;
            drow_reg  <= drow_sel;
            stc_reg   <= stc_sel;
            str_reg   <= str_sel;
            color_reg <= color_sel;
        end
        if (fire)
        begin
            p1_res_reg   <= act_sel;
            p1_on_reg    <= on;
            p1_col_reg   <= on ? ccu[clpg_pkg::DIM_W-1:0] : '0;
            p1_row_reg   <= on ? cru[clpg_pkg::DIM_W-1:0] : '0;
            p1_color_reg <= act_sel ? color_sel : '0;
            p1_last_reg  <= act_sel && fin;
        end
    end

    // Word index: row times stride plus column; both are zero for a clipped pixel.
    assign prod = PROD_W'(p1_row_reg) * PROD_W'(cfg.row_stride_words);
    assign sum  = {1'b0, prod} + {{(PROD_W+1-clpg_pkg::DIM_W){1'b0}}, p1_col_reg};

    always_comb
    begin
        out_data.valid_res   = p1_res_reg;
        out_data.on_screen   = p1_on_reg;
        out_data.pixel_index = {{(clpg_pkg::INDEX_W-PROD_W-1){1'b0}}, sum};
        out_data.pixel_color = p1_color_reg;
        out_data.last        = p1_last_reg;
    end

    assign out_push = p1_valid_reg;

endmodule

// ===== rtl/clipped_line_pixel_generator.sv =====
// Top level of the clipped line pixel generator.
// Throughput: one item per clock while the command queue has room; the stepper takes one
// command each cycle from its queue while the result queue has room for it.
// The multiplier for the word index sits one register after the stepper.
// Reset clears both queues, the active-line flag and the frame registers; no clearing pass.
`include "clipped_line_pixel_generator_macros.svh"

module clipped_line_pixel_generator #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  kind,
    input  logic signed [clpg_pkg::FIELD_W-1:0]   start_x,
    input  logic signed [clpg_pkg::FIELD_W-1:0]   start_y,
    input  logic signed [clpg_pkg::FIELD_W-1:0]   end_x,
    input  logic signed [clpg_pkg::FIELD_W-1:0]   end_y,
    input  logic [clpg_pkg::COLOR_W-1:0]          color,
    output logic                                  empty,
    input  logic                                  pop,
    output logic                                  valid_res,
    output logic                                  on_screen,
    output logic [clpg_pkg::INDEX_W-1:0]          pixel_index,
    output logic [clpg_pkg::COLOR_W-1:0]          pixel_color,
    output logic                                  last,
    input  logic                                  cfg_write,
    input  logic [clpg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [clpg_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int CMD_W     = clpg_pkg::cmd_bits(clpg_pkg::coord_bits(COORD_BITS));
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int RES_W     = $bits(clpg_pkg::res_t);

    clpg_pkg::cfg_t cfg_reg, cfg_next;

    logic                                  cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic [CMD_W-1:0]                      cmd_wdata, cmd_rdata;
    logic                                  out_push, out_full;
    logic [$clog2(OUT_DEPTH+1)-1:0]        out_level;
    clpg_pkg::res_t                        out_wdata, out_rdata;

    // Frame geometry registers.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                clpg_pkg::CFG_FRAME_WIDTH:
                begin
                    cfg_next.frame_width = cfg_data[clpg_pkg::DIM_W-1:0];
                end
                clpg_pkg::CFG_FRAME_HEIGHT:
                begin
                    cfg_next.frame_height = cfg_data[clpg_pkg::DIM_W-1:0];
                end
                clpg_pkg::CFG_ROW_STRIDE:
                begin
                    cfg_next.row_stride_words = cfg_data[clpg_pkg::STRIDE_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end and command queue.
    clpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .push     (push),
        .full     (full),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .kind     (kind),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .color    (color),
        .cmd_data (cmd_wdata)
    );

    clpg_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty),
        .level ()
    );

    // Back end and result queue.
    clpg_back #(
        .COORD_BITS (COORD_BITS),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_data  (cmd_rdata),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_level (out_level),
        .out_push  (out_push),
        .out_data  (out_wdata)
    );

    clpg_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty),
        .level (out_level)
    );

    // Result ports.
    assign valid_res   = out_rdata.valid_res;
    assign on_screen   = out_rdata.on_screen;
    assign pixel_index = out_rdata.pixel_index;
    assign pixel_color = out_rdata.pixel_color;
    assign last        = out_rdata.last;

    // The back end reserves queue space before it takes a command.
    `CLPG_ASSERT_IMPLY(a_out_no_overflow, out_push, !out_full, "result queue overflow")
    // Every command taken by the stepper reaches the result queue in the next cycle.
    `CLPG_ASSERT_NEXT(a_cmd_to_result, cmd_pop, out_push, "command lost in back end")
    // A beat with no line in progress carries all zero fields.
    `CLPG_ASSERT_IMPLY(a_idle_zero, !empty && !valid_res, !on_screen && pixel_index == '0 && pixel_color == '0 && !last, "idle result not zero")
    // A clipped pixel reports a zero word index.
    `CLPG_ASSERT_IMPLY(a_clip_zero, !empty && !on_screen, pixel_index == '0, "clipped pixel has index")

endmodule

// ===== test/line_checker.sv =====
// Scoreboard for the line pixel generator: predicts every pixel beat and compares it.
`timescale 1ns / 1ps

module line_checker #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  logic                                  full,
    input  logic                                  kind,
    input  logic signed [clpg_pkg::FIELD_W-1:0]   start_x,
    input  logic signed [clpg_pkg::FIELD_W-1:0]   start_y,
    input  logic signed [clpg_pkg::FIELD_W-1:0]   end_x,
    input  logic signed [clpg_pkg::FIELD_W-1:0]   end_y,
    input  logic [clpg_pkg::COLOR_W-1:0]          color,
    input  logic                                  empty,
    input  logic                                  pop,
    input  logic                                  valid_res,
    input  logic                                  on_screen,
    input  logic [clpg_pkg::INDEX_W-1:0]          pixel_index,
    input  logic [clpg_pkg::COLOR_W-1:0]          pixel_color,
    input  logic                                  last,
    input  logic                                  cfg_write,
    input  logic [clpg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [clpg_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                    fail_count,
    output int                                    pending
);

    // Endpoints are narrowed to at most 16 significant bits.
    localparam int IN_BITS = (COORD_BITS < clpg_pkg::FIELD_W) ? COORD_BITS : clpg_pkg::FIELD_W;

    // Frame geometry as last written.
    logic [clpg_pkg::DIM_W-1:0]    fb_width;
    logic [clpg_pkg::DIM_W-1:0]    fb_height;
    logic [clpg_pkg::STRIDE_W-1:0] fb_stride;

    // Line walker state.
    logic                          line_active;
    longint                        col_pos;
    longint                        row_pos;
    longint                        col_goal;
    longint                        row_goal;
    longint                        col_span;
    longint                        row_span;
    longint                        col_dir;
    longint                        row_dir;
    longint                        err_acc;
    logic [clpg_pkg::COLOR_W-1:0]  line_rgb;

    // Pixels predicted but not yet popped, oldest first.
    clpg_pkg::res_t                pixel_queue[$];
    int                            mismatches;

    assign fail_count = mismatches;

    // Print one line for a failure and count it.
    task report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        mismatches++;
    endtask

    task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
        begin
            report_error($sformatf("%s mismatch: got %h, expected %h", name, got, want));
        end
    endtask

    // Sign-extend an endpoint from the narrowed coordinate width.
    function automatic longint widen_coord(input logic [clpg_pkg::FIELD_W-1:0] raw);
        longint v;
        v = longint'(raw);
        v = v & ((longint'(1) << IN_BITS) - 1);
        if (v >= (longint'(1) << (IN_BITS - 1)))
        begin
            v = v - (longint'(1) << IN_BITS);
        end
        return v;
    endfunction

    // Report the current pixel, then take one Bresenham step unless it was the endpoint.
    task emit_pixel(output clpg_pkg::res_t r);
        longint w;
        longint h;
        longint s;
        longint idx;
        longint e2;
        logic   on;
        logic   fin;
        w = longint'(fb_width);
        h = longint'(fb_height);
        s = longint'(fb_stride);
        on = (col_pos >= 0) && (row_pos >= 0) && (col_pos < w) && (row_pos < h);
        fin = (col_pos == col_goal) && (row_pos == row_goal);
        idx = row_pos * s + col_pos;
        r.valid_res = 1'b1;
        r.on_screen = on;
        r.pixel_index = on ? idx[31:0] : '0;
        r.pixel_color = line_rgb;
        r.last = fin;
        if (fin)
        begin
            line_active = 1'b0;
        end
        else
        begin
            e2 = 2 * err_acc;
            if (e2 > -row_span)
            begin
                err_acc = err_acc - row_span;
                col_pos = col_pos + col_dir;
            end
            if (e2 < col_span)
            begin
                err_acc = err_acc + col_span;
                row_pos = row_pos + row_dir;
            end
        end
    endtask

    // Expected result beat for one accepted input beat.
    task predict_pixel(output clpg_pkg::res_t r);
        longint dx;
        longint dy;
        r = '0;
        if (kind == clpg_pkg::KIND_START)
        begin
            col_pos = widen_coord(start_x);
            row_pos = widen_coord(start_y);
            col_goal = widen_coord(end_x);
            row_goal = widen_coord(end_y);
            line_rgb = color;
            dx = col_goal - col_pos;
            dy = row_goal - row_pos;
            col_span = (dx < 0) ? -dx : dx;
            row_span = (dy < 0) ? -dy : dy;
            col_dir = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
            row_dir = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
            err_acc = col_span - row_span;
            line_active = 1'b1;
            emit_pixel(r);
        end
        else if (line_active)
        begin
            emit_pixel(r);
        end
    endtask

    // Track configuration, compare popped beats, then predict pushed beats.
    always @(posedge clk or negedge rst_n)
    begin : track
        clpg_pkg::res_t want;
        if (!rst_n)
        begin
            fb_width = '0;
            fb_height = '0;
            fb_stride = '0;
            line_active = 1'b0;
            col_pos = 0;
            row_pos = 0;
            col_goal = 0;
            row_goal = 0;
            col_span = 0;
            row_span = 0;
            col_dir = 0;
            row_dir = 0;
            err_acc = 0;
            line_rgb = '0;
            pixel_queue.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    clpg_pkg::CFG_FRAME_WIDTH:  fb_width = cfg_data[clpg_pkg::DIM_W-1:0];
                    clpg_pkg::CFG_FRAME_HEIGHT: fb_height = cfg_data[clpg_pkg::DIM_W-1:0];
                    clpg_pkg::CFG_ROW_STRIDE:   fb_stride = cfg_data[clpg_pkg::STRIDE_W-1:0];
                    default:                    ;
                endcase
            end
            if (pop && !empty)
            begin
                if (pixel_queue.size() == 0)
                begin
                    report_error("result beat with no expected pixel");
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    check_field("valid_res", 32'(valid_res), 32'(want.valid_res));
                    check_field("on_screen", 32'(on_screen), 32'(want.on_screen));
                    check_field("pixel_index", pixel_index, want.pixel_index);
                    check_field("pixel_color", pixel_color, want.pixel_color);
                    check_field("last", 32'(last), 32'(want.last));
                end
            end
            if (push && !full)
            begin
                predict_pixel(want);
                pixel_queue.push_back(want);
            end
            pending <= pixel_queue.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the line pixel generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int COORD_BITS = 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASES     = 6;
    localparam int PHASE_ITEMS = 250;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   push;
    logic                                   full;
    logic                                   kind;
    logic signed [clpg_pkg::FIELD_W-1:0]    start_x;
    logic signed [clpg_pkg::FIELD_W-1:0]    start_y;
    logic signed [clpg_pkg::FIELD_W-1:0]    end_x;
    logic signed [clpg_pkg::FIELD_W-1:0]    end_y;
    logic [clpg_pkg::COLOR_W-1:0]           color;
    logic                                   empty;
    logic                                   pop;
    logic                                   valid_res;
    logic                                   on_screen;
    logic [clpg_pkg::INDEX_W-1:0]           pixel_index;
    logic [clpg_pkg::COLOR_W-1:0]           pixel_color;
    logic                                   last;
    logic                                   cfg_write;
    logic [clpg_pkg::CFG_IDX_W-1:0]         cfg_index;
    logic [clpg_pkg::CFG_DATA_W-1:0]        cfg_data;

    int                           fail_count;
    int                           pending;
    int                           send_idle;
    int                           recv_idle;
    int                           sent_items;
    int                           frame_w;
    int                           frame_h;
    int                           idle_cycles;

    clipped_line_pixel_generator #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .color       (color),
        .empty       (empty),
        .pop         (pop),
        .valid_res   (valid_res),
        .on_screen   (on_screen),
        .pixel_index (pixel_index),
        .pixel_color (pixel_color),
        .last        (last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    line_checker #(
        .COORD_BITS (COORD_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .color       (color),
        .empty       (empty),
        .pop         (pop),
        .valid_res   (valid_res),
        .on_screen   (on_screen),
        .pixel_index (pixel_index),
        .pixel_color (pixel_color),
        .last        (last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Free-running clock, 8 ns period.
    always #4 clk = ~clk;

    // The result side pops at random according to the current idle rate.
    always @(posedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Watchdog: too many cycles without any accepted beat ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one input beat after a random gap and hold it until it is taken.
    task send_item(input logic k, input logic signed [clpg_pkg::FIELD_W-1:0] sx,
                   input logic signed [clpg_pkg::FIELD_W-1:0] sy,
                   input logic signed [clpg_pkg::FIELD_W-1:0] ex,
                   input logic signed [clpg_pkg::FIELD_W-1:0] ey,
                   input logic [clpg_pkg::COLOR_W-1:0] col);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        kind <= k;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        color <= col;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        sent_items++;
    endtask

    // A start beat followed by a number of advance beats with junk endpoints.
    task send_line(input int sx, input int sy, input int ex, input int ey,
                   input logic [clpg_pkg::COLOR_W-1:0] col, input int steps);
        send_item(clpg_pkg::KIND_START, 16'(sx), 16'(sy), 16'(ex), 16'(ey), col);
        repeat (steps)
        begin
            send_item(clpg_pkg::KIND_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), $urandom);
        end
    endtask

    // Stop sending and wait until every predicted pixel has been popped.
    task drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    // Program the frame geometry; only called while the block is idle.
    task write_frame(input logic [clpg_pkg::CFG_DATA_W-1:0] w,
                     input logic [clpg_pkg::CFG_DATA_W-1:0] h,
                     input logic [clpg_pkg::CFG_DATA_W-1:0] s);
        cfg_write <= 1'b1;
        cfg_index <= clpg_pkg::CFG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= clpg_pkg::CFG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_index <= clpg_pkg::CFG_ROW_STRIDE;
        cfg_data <= s;
        @(posedge clk);
        cfg_write <= 1'b0;
        frame_w = int'(w[clpg_pkg::DIM_W-1:0]);
        frame_h = int'(h[clpg_pkg::DIM_W-1:0]);
    endtask

    // Coordinate around the visible range, a little outside on both sides.
    function automatic int near_frame(input int extent);
        int v;
        v = $urandom_range(0, extent + 40);
        return v - 20;
    endfunction

    // Hand-picked lines for a 64 by 48 frame with a stride of 80 words.
    task run_directed();
        // Advance with no line in progress.
        send_item(clpg_pkg::KIND_ADVANCE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                  32'hFFFF_FFFF);
        // Shallow line walked to its end, then one advance past it.
        send_line(0, 0, 3, 1, 32'hFFFF_FFFF, 4);
        // Starts off screen at negative coordinates.
        send_line(-2, -1, 1, 2, 32'h1234_5678, 3);
        // Single-point lines, including the coordinate extremes.
        send_line(5, 5, 5, 5, 32'h0000_0000, 0);
        send_line(-32768, -32768, -32768, -32768, 32'hDEAD_BEEF, 0);
        send_line(32767, 32767, 32767, 32767, 32'h8000_0001, 0);
        // Longest possible line, dropped by the next start.
        send_line(-32768, 32767, 32767, -32768, 32'hA5A5_5A5A, 1);
        // Crosses the right edge of the frame.
        send_line(62, 46, 66, 44, 32'h0F0F_F0F0, 4);
        // Steep line.
        send_line(10, 0, 11, 3, 32'h5555_AAAA, 3);
    endtask

    // One random sequence: mostly whole lines, some cut short, some noise.
    task random_burst();
        int pick;
        int span;
        int sx;
        int sy;
        int dx;
        int dy;
        int longest;
        int steps;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0:       span = 2;
            1:       span = 12;
            default: span = 48;
        endcase
        sx = near_frame(frame_w);
        sy = near_frame(frame_h);
        dx = $urandom_range(0, 2 * span);
        dx = dx - span;
        dy = $urandom_range(0, 2 * span);
        dy = dy - span;
        longest = (dx < 0) ? -dx : dx;
        if (((dy < 0) ? -dy : dy) > longest)
        begin
            longest = (dy < 0) ? -dy : dy;
        end
        if (pick < 75)
        begin
            // Whole line, sometimes with advances past its end.
            steps = longest;
            if ($urandom_range(0, 4) == 0)
            begin
                steps = steps + $urandom_range(1, 2);
            end
            send_line(sx, sy, sx + dx, sy + dy, $urandom, steps);
        end
        else if (pick < 85)
        begin
            // Line that may be cut short by the next start.
            send_line(sx, sy, sx + dx, sy + dy, $urandom, $urandom_range(0, longest));
        end
        else if (pick < 95)
        begin
            // Endpoints anywhere in the coordinate space.
            send_line($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 4));
        end
        else
        begin
            // Stray advances.
            repeat ($urandom_range(1, 3))
            begin
                send_item(clpg_pkg::KIND_ADVANCE, 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), $urandom);
            end
        end
    endtask

    // Main sequence: reset, then phases of frame settings and traffic.
    initial
    begin : main
        int phase;
        int phase_goal;
        int w;
        int h;
        bit paused;
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        kind = clpg_pkg::KIND_START;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        color = '0;
        pop = 1'b0;
        cfg_write = 1'b0;
        cfg_index = clpg_pkg::CFG_FRAME_WIDTH;
        cfg_data = '0;
        send_idle = 33;
        recv_idle = 61;
        sent_items = 0;
        frame_w = 0;
        frame_h = 0;
        idle_cycles = 0;
        paused = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (phase = 0; phase < PHASES; phase++)
        begin
            // Idle pattern: receiver-heavy gaps, then sender-heavy, then none.
            case (phase / 2)
                0:
                begin
                    send_idle = 33;
                    recv_idle = 61;
                end
                1:
                begin
                    send_idle = 61;
                    recv_idle = 33;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            // Frame geometry for this phase, extremes included.
            case (phase)
                0: write_frame(16'd64, 16'd48, 16'd80);
                1: write_frame(16'd0, 16'd16383, 16'd65535);
                2: write_frame(16'hFFFF, 16'hFFFF, 16'd65535);
                3: write_frame(16'd100, 16'd0, 16'd0);
                4:
                begin
                    w = $urandom_range(1, 200);
                    h = $urandom_range(1, 200);
                    write_frame(16'(w), 16'(h), 16'(w + $urandom_range(0, 20)));
                end
                default:
                begin
                    w = $urandom_range(1, 300);
                    h = $urandom_range(1, 300);
                    write_frame(16'(w), 16'(h), 16'($urandom_range(0, 65535)));
                end
            endcase
            if (phase == 0)
            begin
                run_directed();
            end
            phase_goal = sent_items + PHASE_ITEMS;
            while (sent_items < phase_goal)
            begin
                // Once, mid-way through phase 2, hold off until every pixel has come back.
                if (phase == 2 && !paused && sent_items >= phase_goal - PHASE_ITEMS / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                random_burst();
            end
            drain_results();
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
